// ===== rtl/fcgi_rd_pkg.sv =====
// Package for the FastCGI record deframer: record type codes, header
// offsets, event codes, parse phase type and the result item struct.
// No dependencies.
package fcgi_rd_pkg;

    localparam logic [7:0] TYPE_END_REQUEST = 8'd3;
    localparam logic [7:0] TYPE_STDOUT      = 8'd6;

    // Byte offsets inside the 8-byte record header.
    localparam logic [2:0] HDR_TYPE     = 3'd1;
    localparam logic [2:0] HDR_LEN_HIGH = 3'd4;
    localparam logic [2:0] HDR_LEN_LOW  = 3'd5;
    localparam logic [2:0] HDR_PAD_LEN  = 3'd6;
    localparam logic [2:0] HDR_LAST     = 3'd7;

    localparam logic EV_STDOUT_BYTE = 1'b0;
    localparam logic EV_REQ_ENDED   = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2
    } t_phase;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] data_byte;
        logic       last_in_record;
    } t_result;

endpackage

// ===== rtl/fastcgi_record_deframer.sv =====
// FastCGI record deframer: one stream byte per request in, stdout content
// bytes and request-ended events out. An accepted byte's result goes to the
// output register, or to the skid register if the output is stalled; one
// byte is taken every cycle while the output side drains, the skid register
// absorbing one output stall. Reset (synchronous, active low) returns the
// parser to the start of a record header and empties the output and skid registers.
// Depends on fcgi_rd_pkg.
module fastcgi_record_deframer
    import fcgi_rd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_event_kind,
    output logic [7:0] o_data_byte,
    output logic       o_last_in_record
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_len_high, n_len_high;
    logic [15:0] r_content_left, n_content_left;
    logic [7:0]  r_pad_left, n_pad_left;

    logic        r_out_valid, r_skid_valid;
    t_result     r_out, r_skid;

    logic        in_acc, out_free, res_valid;
    t_result     res;

    assign in_acc   = i_in_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_phase        = r_phase;
        n_hdr_cnt      = r_hdr_cnt;
        n_type         = r_type;
        n_len_high     = r_len_high;
        n_content_left = r_content_left;
        n_pad_left     = r_pad_left;
        res_valid      = 1'b0;
        res            = '{event_kind: EV_STDOUT_BYTE, data_byte: 8'd0, last_in_record: 1'b0};

        unique case (r_phase)
            PH_CONTENT: begin
                if (r_type == TYPE_STDOUT) begin
                    res_valid = 1'b1;
                    res = '{event_kind: EV_STDOUT_BYTE, data_byte: i_byte_value,
                            last_in_record: (r_content_left == 16'd1)};
                end
                n_content_left = r_content_left - 16'd1;
                if (n_content_left == 16'd0) begin
                    n_hdr_cnt = 3'd0;
                    if (r_pad_left != 8'd0) begin
                        n_phase = PH_PADDING;
                    end else begin
                        n_phase = PH_HEADER;
                        if (r_type == TYPE_END_REQUEST) begin
                            res_valid = 1'b1;
                            res = '{event_kind: EV_REQ_ENDED, data_byte: 8'd0,
                                    last_in_record: 1'b0};
                        end
                    end
                end
            end
            PH_PADDING: begin
                n_pad_left = r_pad_left - 8'd1;
                if (n_pad_left == 8'd0) begin
                    n_phase   = PH_HEADER;
                    n_hdr_cnt = 3'd0;
                    if (r_type == TYPE_END_REQUEST) begin
                        res_valid = 1'b1;
                        res = '{event_kind: EV_REQ_ENDED, data_byte: 8'd0,
                                last_in_record: 1'b0};
                    end
                end
            end
            default: begin
                // Header phase; the unused phase code is parsed as header too.
                n_phase = PH_HEADER;
                case (r_hdr_cnt)
                    HDR_TYPE:     n_type = i_byte_value;
                    HDR_LEN_HIGH: n_len_high = i_byte_value;
                    HDR_LEN_LOW:  n_content_left = {r_len_high, i_byte_value};
                    HDR_PAD_LEN:  n_pad_left = i_byte_value;
                    default:      ;
                endcase
                n_hdr_cnt = r_hdr_cnt + 3'd1;
                if (r_hdr_cnt == HDR_LAST) begin
                    n_hdr_cnt = 3'd0;
                    if (n_content_left != 16'd0) begin
                        n_phase = PH_CONTENT;
                    end else if (n_pad_left != 8'd0) begin
                        n_phase = PH_PADDING;
                    end else if (n_type == TYPE_END_REQUEST) begin
                        res_valid = 1'b1;
                        res = '{event_kind: EV_REQ_ENDED, data_byte: 8'd0,
                                last_in_record: 1'b0};
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_hdr_cnt      <= 3'd0;
            r_type         <= 8'd0;
            r_len_high     <= 8'd0;
            r_content_left <= 16'd0;
            r_pad_left     <= 8'd0;
        end else if (in_acc) begin
            r_phase        <= n_phase;
            r_hdr_cnt      <= n_hdr_cnt;
            r_type         <= n_type;
            r_len_high     <= n_len_high;
            r_content_left <= n_content_left;
            r_pad_left     <= n_pad_left;
        end
    end

    // The skid register only fills when a result arrives while the output
    // register is stalled; it then blocks input until it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_acc && res_valid) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (in_acc && res_valid) begin
            if (out_free) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_event_kind     = r_out.event_kind;
    assign o_data_byte      = r_out.data_byte;
    assign o_last_in_record = r_out.last_in_record;

endmodule

// ===== bench/fastcgi_record_deframer_tb.sv =====
// Self-checking testbench for fastcgi_record_deframer: drives whole FastCGI records
// with random content and idling on both sides, and checks every result against a
// behavioral predictor kept in a scoreboard class. Depends on fcgi_rd_pkg and the RTL.
`timescale 1ns / 100ps

module fastcgi_record_deframer_tb;
    import fcgi_rd_pkg::*;

    class deframe_scoreboard;
        t_phase      phase;
        logic [2:0]  hdr_idx;
        logic [7:0]  rec_kind;
        logic [7:0]  len_high;
        logic [15:0] content_left;
        logic [7:0]  pad_left;
        t_result     pending[$];
        int          errors;
        int          bytes_seen;
        int          stdout_bytes;
        int          ends_seen;

        function new();
            phase        = PH_HEADER;
            hdr_idx      = '0;
            rec_kind     = '0;
            len_high     = '0;
            content_left = '0;
            pad_left     = '0;
            errors       = 0;
            bytes_seen   = 0;
            stdout_bytes = 0;
            ends_seen    = 0;
        endfunction

        function void end_record();
            t_result ev;
            phase   = PH_HEADER;
            hdr_idx = '0;
            if (rec_kind == TYPE_END_REQUEST) begin
                ev.event_kind     = EV_REQ_ENDED;
                ev.data_byte      = 8'h00;
                ev.last_in_record = 1'b0;
                pending.push_back(ev);
                ends_seen++;
            end
        endfunction

        function void end_content();
            if (pad_left != 0) begin
                phase = PH_PADDING;
            end else begin
                end_record();
            end
        endfunction

        // Called for every accepted stream byte; queues the result it causes.
        function void note_byte(logic [7:0] b);
            t_result res;
            bytes_seen++;
            case (phase)
                PH_CONTENT: begin
                    if (rec_kind == TYPE_STDOUT) begin
                        res.event_kind     = EV_STDOUT_BYTE;
                        res.data_byte      = b;
                        res.last_in_record = (content_left == 16'd1);
                        pending.push_back(res);
                        stdout_bytes++;
                    end
                    content_left = content_left - 16'd1;
                    if (content_left == 0) end_content();
                end
                PH_PADDING: begin
                    pad_left = pad_left - 8'd1;
                    if (pad_left == 0) end_record();
                end
                default: begin
                    phase = PH_HEADER;
                    case (hdr_idx)
                        HDR_TYPE:     rec_kind = b;
                        HDR_LEN_HIGH: len_high = b;
                        HDR_LEN_LOW:  content_left = {len_high, b};
                        HDR_PAD_LEN:  pad_left = b;
                        default: ;
                    endcase
                    if (hdr_idx == HDR_LAST) begin
                        hdr_idx = '0;
                        if (content_left != 0) begin
                            phase = PH_CONTENT;
                        end else begin
                            end_content();
                        end
                    end else begin
                        hdr_idx = hdr_idx + 3'd1;
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic kind, logic [7:0] data, logic last);
            t_result exp;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind=%0b data=%02h last=%0b",
                                 kind, data, last));
            end else begin
                exp = pending.pop_front();
                if (kind !== exp.event_kind)
                    report($sformatf("event_kind got %0b, want %0b", kind, exp.event_kind));
                if (data !== exp.data_byte)
                    report($sformatf("data_byte got %02h, want %02h", data, exp.data_byte));
                if (last !== exp.last_in_record)
                    report($sformatf("last_in_record got %0b, want %0b",
                                     last, exp.last_in_record));
            end
        endtask
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_byte_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_event_kind;
    logic [7:0] o_data_byte;
    logic       o_last_in_record;

    deframe_scoreboard sb = new();
    bit                gaps_on = 1'b1;
    bit                out_quiet = 1'b0;
    bit                hold_off_req = 1'b0;

    fastcgi_record_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_value     (i_byte_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_kind     (o_event_kind),
        .o_data_byte      (o_data_byte),
        .o_last_in_record (o_last_in_record)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // Both monitors sample the pre-edge values of the handshake signals.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_byte(i_byte_value);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_event_kind, o_data_byte, o_last_in_record);
    end

    // Output side: random stalls, quiet stretches, and one long hold-off on request.
    initial begin
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_stall <= 1'b1;
                repeat (80) @(posedge i_clk);
                hold_off_req = 1'b0;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (out_quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = idle_len();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    task drive_byte(logic [7:0] b);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // One whole record; fill < 0 gives random content bytes.
    task send_record(logic [7:0] kind, logic [15:0] len, logic [7:0] pad, int fill = -1);
        drive_byte(8'($urandom));
        drive_byte(kind);
        drive_byte(8'($urandom));
        drive_byte(8'($urandom));
        drive_byte(len[15:8]);
        drive_byte(len[7:0]);
        drive_byte(pad);
        drive_byte(8'($urandom));
        for (int i = 0; i < len; i++) drive_byte(fill < 0 ? 8'($urandom) : fill[7:0]);
        for (int i = 0; i < pad; i++) drive_byte(8'($urandom));
    endtask

    initial begin
        int r;
        int waited;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_byte_value <= 8'h00;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single maximal content byte, an empty stdout record, and an
        // end-request record that finishes on its last header byte.
        send_record(TYPE_STDOUT, 16'd1, 8'd0, 8'hFF);
        send_record(TYPE_STDOUT, 16'd0, 8'd0);
        send_record(TYPE_END_REQUEST, 16'd0, 8'd0);

        // The receiver holds off while the sender streams without gaps.
        gaps_on = 1'b0;
        hold_off_req = 1'b1;
        send_record(TYPE_STDOUT, 16'd60, 8'd0);

        // A record whose length uses the high length byte, sent back to back.
        send_record(TYPE_END_REQUEST, 16'h0104, 8'h02);

        while (sb.bytes_seen < 600) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            out_quiet = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 45)
                send_record(TYPE_STDOUT, 16'($urandom_range(0, 24)),
                            ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 7)) : 8'd0);
            else if (r < 65)
                send_record(TYPE_END_REQUEST, 16'($urandom_range(0, 8)),
                            8'($urandom_range(0, 3)));
            else if (r < 68)
                send_record(TYPE_STDOUT, 16'($urandom_range(250, 300)),
                            8'($urandom_range(0, 2)));
            else
                send_record(8'($urandom), 16'($urandom_range(0, 16)),
                            8'($urandom_range(0, 7)));
        end
        i_in_valid <= 1'b0;
        out_quiet = 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));

        $display("Run covered %0d stream bytes, %0d stdout content bytes and %0d ended requests,",
                 sb.bytes_seen, sb.stdout_bytes, sb.ends_seen);
        $display("with a long output hold-off and a record over 255 bytes; %0d mismatches.",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: the run did not complete.");
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/fcgi_rd_pkg.sv
rtl/fastcgi_record_deframer.sv
bench/fastcgi_record_deframer_tb.sv
